>>> hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, codes and constants of the binary program enumerator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_MAX_VARS   = 16;
  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_COEF_WIDTH = 16;

  // Fixed field widths of the channels
  localparam int CMD_W      = 2;
  localparam int ROW_IN_W   = 4;
  localparam int COL_IN_W   = 4;
  localparam int COEF_IN_W  = 16;
  localparam int BOUND_W    = 21;
  localparam int KIND_W     = 2;
  localparam int SOL_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_REG_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(1);

  // Reset values of the configuration registers
  localparam logic [CFG_REG_W-1:0] NUM_VARS_RST = CFG_REG_W'(1);
  localparam logic [CFG_REG_W-1:0] NUM_ROWS_RST = CFG_REG_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_LOAD_ROW  = 2'd1,
    CMD_REWIND    = 2'd2,
    CMD_FIND      = 2'd3
  } cmd_t;

  // Relation kinds; the unused code places no constraint
  typedef enum logic [KIND_W-1:0] {
    KIND_EQ = 2'd0,
    KIND_LE = 2'd1,
    KIND_GE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROW,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_RESP
  } state_t;

  // Sequencer to accumulator controls
  typedef struct packed {
    logic acc_clr;
    logic add_issue;
  } alu_ctrl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> hw/rtl/bpe_if.sv
// ----------------------------------------------------------------------------
// bpe_if
// Valid/ready channels of the enumerator: command, result and configuration.
// ----------------------------------------------------------------------------
interface bpe_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bpe_pkg::CMD_W-1:0]     cmd;
  logic        [bpe_pkg::ROW_IN_W-1:0]  row;
  logic        [bpe_pkg::COL_IN_W-1:0]  col;
  logic signed [bpe_pkg::COEF_IN_W-1:0] coef;
  logic signed [bpe_pkg::BOUND_W-1:0]   bound;
  logic        [bpe_pkg::KIND_W-1:0]    kind;

  modport source (output valid, cmd, row, col, coef, bound, kind, input ready);
  modport sink   (input valid, cmd, row, col, coef, bound, kind, output ready);
endinterface

interface bpe_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [bpe_pkg::SOL_W-1:0]    solution;

  modport source (output valid, found, solution, input ready);
  modport sink   (input valid, found, solution, output ready);
endinterface

interface bpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpe_pkg::CFG_IDX_W-1:0]   index;
  logic [bpe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bpe_store.sv
// ----------------------------------------------------------------------------
// bpe_store
// Coefficient, bound and kind memories with load decode and registered reads.
// ----------------------------------------------------------------------------
module bpe_store #(
  parameter int MAX_VARS   = bpe_pkg::DEF_MAX_VARS,
  parameter int MAX_ROWS   = bpe_pkg::DEF_MAX_ROWS,
  parameter int COEF_WIDTH = bpe_pkg::DEF_COEF_WIDTH,
  parameter int ADDR_W     = 8,
  parameter int ROW_W      = 4
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic        [bpe_pkg::CMD_W-1:0]     cmd,
  input  logic        [bpe_pkg::ROW_IN_W-1:0]  row,
  input  logic        [bpe_pkg::COL_IN_W-1:0]  col,
  input  logic signed [bpe_pkg::COEF_IN_W-1:0] coef,
  input  logic signed [bpe_pkg::BOUND_W-1:0]   bound,
  input  logic        [bpe_pkg::KIND_W-1:0]    kind,
  input  logic        [ADDR_W-1:0]             coef_addr,
  input  logic        [ROW_W-1:0]              row_addr,
  output logic signed [COEF_WIDTH-1:0]         coef_q,
  output logic signed [bpe_pkg::BOUND_W-1:0]   bound_q,
  output logic        [bpe_pkg::KIND_W-1:0]    kind_q
);
  import bpe_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_VARS;

  logic signed [COEF_WIDTH-1:0] coef_mem  [DEPTH];
  logic signed [BOUND_W-1:0]    bound_mem [MAX_ROWS];
  logic        [KIND_W-1:0]     kind_mem  [MAX_ROWS];

  logic                  row_ok;
  logic                  col_ok;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ROW_W-1:0]      wr_row;
  logic [31:0]           coef_wide;

  // Decode the load address and wrap the coefficient
  always_comb begin
    row_ok    = 32'(row) < MAX_ROWS;
    col_ok    = 32'(col) < MAX_VARS;
    wr_addr   = ADDR_W'(32'(row) * MAX_VARS + 32'(col));
    wr_row    = ROW_W'(32'(row));
    coef_wide = {{(32 - COEF_IN_W){coef[COEF_IN_W-1]}}, coef};
  end

  // Write on a load beat
  always_ff @(posedge clk) begin
    if (load && cmd == CMD_LOAD_COEF && row_ok && col_ok) begin
      coef_mem[wr_addr] <= coef_wide[COEF_WIDTH-1:0];
    end
    if (load && cmd == CMD_LOAD_ROW && row_ok) begin
      bound_mem[wr_row] <= bound;
      kind_mem[wr_row]  <= kind;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    coef_q  <= coef_mem[coef_addr];
    bound_q <= bound_mem[row_addr];
    kind_q  <= kind_mem[row_addr];
  end

endmodule

>>> hw/rtl/bpe_alu.sv
// ----------------------------------------------------------------------------
// bpe_alu
// Shared accumulate unit: sums one row's selected coefficients, one per cycle,
// and checks the sum against the row's bound and relation.
// ----------------------------------------------------------------------------
module bpe_alu #(
  parameter int MAX_VARS   = bpe_pkg::DEF_MAX_VARS,
  parameter int COEF_WIDTH = bpe_pkg::DEF_COEF_WIDTH
) (
  input  logic                               clk,
  input  bpe_pkg::alu_ctrl_t                 ctrl,
  input  logic signed [COEF_WIDTH-1:0]       coef_q,
  input  logic signed [bpe_pkg::BOUND_W-1:0] bound_q,
  input  logic        [bpe_pkg::KIND_W-1:0]  kind_q,
  output logic                               row_ok
);
  import bpe_pkg::*;

  localparam int ACC_W = COEF_WIDTH + $clog2(MAX_VARS + 1);
  localparam int CMP_W = max_int(ACC_W, BOUND_W) + 1;

  logic                    add_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [CMP_W-1:0] lhs;
  logic signed [CMP_W-1:0] rhs;

  // Delay the add flag to meet the registered coefficient read
  always_ff @(posedge clk) begin
    add_q <= ctrl.add_issue;
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (add_q) begin
      acc <= acc + {{(ACC_W - COEF_WIDTH){coef_q[COEF_WIDTH-1]}}, coef_q};
    end
  end

  // Compare the finished sum against the bound
  always_comb begin
    lhs = {{(CMP_W - ACC_W){acc[ACC_W-1]}}, acc};
    rhs = {{(CMP_W - BOUND_W){bound_q[BOUND_W-1]}}, bound_q};
    case (kind_q)
      KIND_EQ: row_ok = (lhs == rhs);
      KIND_LE: row_ok = (lhs <= rhs);
      KIND_GE: row_ok = (lhs >= rhs);
      default: row_ok = 1'b1;
    endcase
  end

endmodule

>>> hw/rtl/bpe_seq.sv
// ----------------------------------------------------------------------------
// bpe_seq
// Sequencer: walks candidate vectors, rows and columns, keeps the cursor and
// holds the result beat.
// ----------------------------------------------------------------------------
module bpe_seq #(
  parameter int MAX_VARS = bpe_pkg::DEF_MAX_VARS,
  parameter int MAX_ROWS = bpe_pkg::DEF_MAX_ROWS,
  parameter int ADDR_W   = 8,
  parameter int ROW_W    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            rewind,
  input  logic [bpe_pkg::CFG_REG_W-1:0]   num_vars,
  input  logic [bpe_pkg::CFG_REG_W-1:0]   num_constraints,
  input  logic                            row_ok,
  input  logic                            rsp_ready,
  output logic                            idle,
  output bpe_pkg::alu_ctrl_t              ctrl,
  output logic [ADDR_W-1:0]               coef_addr,
  output logic [ROW_W-1:0]                row_addr,
  output logic                            rsp_valid,
  output logic                            rsp_found,
  output logic [bpe_pkg::SOL_W-1:0]       rsp_solution
);
  import bpe_pkg::*;

  localparam int VAR_W = max_int(1, $clog2(MAX_VARS));
  localparam int NV_W  = $clog2(MAX_VARS + 1);
  localparam int NR_W  = $clog2(MAX_ROWS + 1);
  localparam int CUR_W = MAX_VARS + 1;

  state_t state;
  state_t state_next;

  logic [CUR_W-1:0] cursor;
  logic [CUR_W-1:0] v;
  logic [ROW_W-1:0] r;
  logic [VAR_W-1:0] j;
  logic [NV_W-1:0]  nv;
  logic [NR_W-1:0]  nr;
  logic             pend_found;
  logic [CUR_W-1:0] pend_vec;

  logic [CUR_W-1:0] end_v;
  logic [CUR_W-1:0] v_next;
  logic [31:0]      pend_wide;
  logic             j_last;
  logic             r_last;
  logic             v_last;
  logic             past_end;
  logic             out_free;

  // Loop bounds and flags
  always_comb begin
    end_v     = CUR_W'(1) << nv;
    v_next    = v + CUR_W'(1);
    v_last    = (v_next == end_v);
    j_last    = (32'(j) + 1 == 32'(nv));
    r_last    = (32'(r) + 1 == 32'(nr));
    past_end  = (cursor >= end_v);
    out_free  = !rsp_valid || rsp_ready;
    pend_wide = 32'(pend_vec);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_START;
      S_START: state_next = (past_end || nr == '0) ? S_RESP : S_ROW;
      S_ROW:   state_next = (nv == '0) ? S_DRAIN : S_SCAN;
      S_SCAN:  if (j_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_CHECK;
      S_CHECK: begin
        if (row_ok) begin
          state_next = r_last ? S_RESP : S_ROW;
        end else begin
          state_next = v_last ? S_RESP : S_ROW;
        end
      end
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    idle           = (state == S_IDLE);
    ctrl.acc_clr   = (state == S_ROW);
    ctrl.add_issue = (state == S_SCAN) && v[j];
    coef_addr      = ADDR_W'(32'(r) * MAX_VARS + 32'(j));
    row_addr       = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cursor, loop counters and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rewind) begin
            cursor <= '0;
          end
          if (start) begin
            nv <= (32'(num_vars) > MAX_VARS) ? NV_W'(MAX_VARS) : NV_W'(32'(num_vars));
            nr <= (32'(num_constraints) > MAX_ROWS) ? NR_W'(MAX_ROWS)
                                                    : NR_W'(32'(num_constraints));
          end
        end
        S_START: begin
          v <= cursor;
          r <= '0;
          if (past_end) begin
            pend_found <= 1'b0;
            pend_vec   <= '0;
          end else if (nr == '0) begin
            pend_found <= 1'b1;
            pend_vec   <= cursor;
            cursor     <= cursor + CUR_W'(1);
          end
        end
        S_ROW:  j <= '0;
        S_SCAN: j <= j + VAR_W'(1);
        S_DRAIN: ;
        S_CHECK: begin
          if (row_ok) begin
            if (r_last) begin
              pend_found <= 1'b1;
              pend_vec   <= v;
              cursor     <= v_next;
            end else begin
              r <= r + ROW_W'(1);
            end
          end else if (v_last) begin
            pend_found <= 1'b0;
            pend_vec   <= '0;
            cursor     <= v_next;
          end else begin
            v <= v_next;
            r <= '0;
          end
        end
        S_RESP: ;
        default: ;
      endcase
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_RESP && out_free) begin
        rsp_valid    <= 1'b1;
        rsp_found    <= pend_found;
        rsp_solution <= pend_wide[SOL_W-1:0];
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= (CUR_W'(1) << MAX_VARS))
    else $error("cursor beyond the vector space");

  a_scan_col: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> 32'(j) < 32'(nv))
    else $error("column scan past the variable count");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROW |-> 32'(r) < 32'(nr))
    else $error("row walk past the row count");

  a_found_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && pend_found) |-> 32'(cursor) == 32'(pend_vec) + 1)
    else $error("cursor not just past the returned vector");
`endif

endmodule

>>> hw/rtl/binary_program_enumerator.sv
// ----------------------------------------------------------------------------
// binary_program_enumerator
// Exhaustive feasibility search over 0/1 vectors of a small loaded program.
// ----------------------------------------------------------------------------
// Loads and rewind each complete on their command beat; a find sums, for every
// row checked of every candidate tried, the selected coefficients of the row,
// one coefficient a cycle through the single shared accumulator.
// The command channel is not ready while a find is running.
// Reset clears the cursor, the registers (num_vars 1, num_constraints 0) and
// the control state; the coefficient, bound and kind memories are not cleared.
module binary_program_enumerator #(
  parameter int MAX_VARS   = bpe_pkg::DEF_MAX_VARS,
  parameter int MAX_ROWS   = bpe_pkg::DEF_MAX_ROWS,
  parameter int COEF_WIDTH = bpe_pkg::DEF_COEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  bpe_req_if.sink          req,
  bpe_rsp_if.source        rsp,
  bpe_cfg_if.sink          cfg
);
  import bpe_pkg::*;

  localparam int ADDR_W = max_int(1, $clog2(MAX_ROWS * MAX_VARS));
  localparam int ROW_W  = max_int(1, $clog2(MAX_ROWS));

  logic [CFG_REG_W-1:0]         num_vars;
  logic [CFG_REG_W-1:0]         num_constraints;
  logic                         idle;
  logic                         req_beat;
  alu_ctrl_t                    ctrl;
  logic [ADDR_W-1:0]            coef_addr;
  logic [ROW_W-1:0]             row_addr;
  logic signed [COEF_WIDTH-1:0] coef_q;
  logic signed [BOUND_W-1:0]    bound_q;
  logic [KIND_W-1:0]            kind_q;
  logic                         row_ok;

  assign req.ready = idle;
  assign req_beat  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars        <= NUM_VARS_RST;
      num_constraints <= NUM_ROWS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_NUM_VARS: num_vars        <= cfg.data[CFG_REG_W-1:0];
        CFG_NUM_ROWS: num_constraints <= cfg.data[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  bpe_store #(
    .MAX_VARS   (MAX_VARS),
    .MAX_ROWS   (MAX_ROWS),
    .COEF_WIDTH (COEF_WIDTH),
    .ADDR_W     (ADDR_W),
    .ROW_W      (ROW_W)
  ) u_store (
    .clk       (clk),
    .load      (req_beat),
    .cmd       (req.cmd),
    .row       (req.row),
    .col       (req.col),
    .coef      (req.coef),
    .bound     (req.bound),
    .kind      (req.kind),
    .coef_addr (coef_addr),
    .row_addr  (row_addr),
    .coef_q    (coef_q),
    .bound_q   (bound_q),
    .kind_q    (kind_q)
  );

  bpe_alu #(
    .MAX_VARS   (MAX_VARS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_alu (
    .clk     (clk),
    .ctrl    (ctrl),
    .coef_q  (coef_q),
    .bound_q (bound_q),
    .kind_q  (kind_q),
    .row_ok  (row_ok)
  );

  bpe_seq #(
    .MAX_VARS (MAX_VARS),
    .MAX_ROWS (MAX_ROWS),
    .ADDR_W   (ADDR_W),
    .ROW_W    (ROW_W)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (req_beat && req.cmd == CMD_FIND),
    .rewind          (req_beat && req.cmd == CMD_REWIND),
    .num_vars        (num_vars),
    .num_constraints (num_constraints),
    .row_ok          (row_ok),
    .rsp_ready       (rsp.ready),
    .idle            (idle),
    .ctrl            (ctrl),
    .coef_addr       (coef_addr),
    .row_addr        (row_addr),
    .rsp_valid       (rsp.valid),
    .rsp_found       (rsp.found),
    .rsp_solution    (rsp.solution)
  );

endmodule

>>> bench/tb_binary_program_enumerator.sv
// ----------------------------------------------------------------------------
// tb_binary_program_enumerator
// Loads small 0/1 programs, sets the variable and row limits, and issues
// rewind and find-next commands. A predictor in the bench repeats the
// counting-order search on its own copy of the program and cursor, and each
// returned vector is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_binary_program_enumerator;
  timeunit 1ns;
  timeprecision 1ps;

  import bpe_pkg::*;

  localparam int N_VARS         = DEF_MAX_VARS;
  localparam int N_ROWS         = DEF_MAX_ROWS;
  localparam int QUIET_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 100000;

  // Relation code outside kind_t: the row places no constraint
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic signed [COEF_IN_W-1:0] COEF_MAX  = 16'sh7FFF;
  localparam logic signed [COEF_IN_W-1:0] COEF_MIN  = 16'sh8000;
  localparam logic signed [BOUND_W-1:0]   BOUND_MAX = 21'sh0FFFFF;
  localparam logic signed [BOUND_W-1:0]   BOUND_MIN = 21'sh100000;

  typedef struct packed {
    logic             found;
    logic [SOL_W-1:0] solution;
  } search_answer_t;

  logic clk;
  logic rst;

  bpe_req_if req_ch ();
  bpe_rsp_if rsp_ch ();
  bpe_cfg_if cfg_ch ();

  binary_program_enumerator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Bench copy of the program, limits and cursor
  logic signed [COEF_IN_W-1:0] coef_mem    [N_ROWS][N_VARS];
  logic signed [BOUND_W-1:0]   bound_mem   [N_ROWS];
  logic [KIND_W-1:0]           kind_mem    [N_ROWS];
  bit                          coef_loaded [N_ROWS][N_VARS];
  bit                          row_loaded  [N_ROWS];
  logic [CFG_REG_W-1:0]        vars_reg = NUM_VARS_RST;
  logic [CFG_REG_W-1:0]        rows_reg = NUM_ROWS_RST;
  int unsigned                 cursor   = 0;

  search_answer_t answers_due [$];
  search_answer_t oldest;

  int send_gap_pct  = 30;
  int rsp_stall_pct = 65;
  int beats_sent    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  // Check one candidate vector against every active row
  function automatic bit meets_rows(input int unsigned vec, input int nv, input int nr);
    longint lhs;
    for (int r = 0; r < nr; r++) begin
      lhs = 0;
      for (int j = 0; j < nv; j++)
        if (vec[j]) lhs += coef_mem[r][j];
      case (kind_mem[r])
        KIND_EQ: if (lhs != bound_mem[r]) return 1'b0;
        KIND_LE: if (lhs > bound_mem[r]) return 1'b0;
        KIND_GE: if (lhs < bound_mem[r]) return 1'b0;
        default: ;
      endcase
    end
    return 1'b1;
  endfunction

  // Scan from the cursor for the next feasible vector; advance the cursor
  function automatic search_answer_t next_feasible();
    search_answer_t ans;
    int             nv;
    int             nr;
    int unsigned    last;
    nv   = clip(int'(vars_reg), N_VARS);
    nr   = clip(int'(rows_reg), N_ROWS);
    last = 1 << nv;
    ans  = '{found: 1'b0, solution: '0};
    for (int unsigned v = cursor; v < last; v++) begin
      if (meets_rows(v, nv, nr)) begin
        cursor       = v + 1;
        ans.found    = 1'b1;
        ans.solution = v[SOL_W-1:0];
        return ans;
      end
    end
    if (cursor < last) cursor = last;
    return ans;
  endfunction

  function automatic logic signed [COEF_IN_W-1:0] pick_coef();
    if ($urandom_range(7) == 0) return COEF_IN_W'($urandom);
    return COEF_IN_W'(int'($urandom_range(6)) - 3);
  endfunction

  function automatic logic signed [BOUND_W-1:0] pick_bound();
    if ($urandom_range(7) == 0) return BOUND_W'($urandom);
    return BOUND_W'(int'($urandom_range(8)) - 4);
  endfunction

  // Send one command beat and update the predictor when it is taken
  task automatic issue(input cmd_t c, input logic [ROW_IN_W-1:0] row,
                       input logic [COL_IN_W-1:0] col,
                       input logic signed [COEF_IN_W-1:0] coef,
                       input logic signed [BOUND_W-1:0] bound,
                       input logic [KIND_W-1:0] kind);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.row   <= row;
    req_ch.col   <= col;
    req_ch.coef  <= coef;
    req_ch.bound <= bound;
    req_ch.kind  <= kind;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    beats_sent++;
    case (c)
      CMD_LOAD_COEF: begin
        coef_mem[row][col]    = coef;
        coef_loaded[row][col] = 1'b1;
      end
      CMD_LOAD_ROW: begin
        bound_mem[row]  = bound;
        kind_mem[row]   = kind;
        row_loaded[row] = 1'b1;
      end
      CMD_REWIND: cursor = 0;
      default: answers_due.push_back(next_feasible());
    endcase
  endtask

  task automatic load_coef(input logic [ROW_IN_W-1:0] row, input logic [COL_IN_W-1:0] col,
                           input logic signed [COEF_IN_W-1:0] value);
    issue(CMD_LOAD_COEF, row, col, value, BOUND_W'($urandom), KIND_W'($urandom));
  endtask

  task automatic load_row(input logic [ROW_IN_W-1:0] row,
                          input logic signed [BOUND_W-1:0] bound,
                          input logic [KIND_W-1:0] kind);
    issue(CMD_LOAD_ROW, row, COL_IN_W'($urandom), COEF_IN_W'($urandom), bound, kind);
  endtask

  task automatic rewind_cursor();
    issue(CMD_REWIND, ROW_IN_W'($urandom), COL_IN_W'($urandom), COEF_IN_W'($urandom),
          BOUND_W'($urandom), KIND_W'($urandom));
  endtask

  task automatic seek_next();
    issue(CMD_FIND, ROW_IN_W'($urandom), COL_IN_W'($urandom), COEF_IN_W'($urandom),
          BOUND_W'($urandom), KIND_W'($urandom));
  endtask

  // Hold the command channel until every answer is back and loads are done
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_NUM_VARS) vars_reg = val[CFG_REG_W-1:0];
    else if (idx == CFG_NUM_ROWS) rows_reg = val[CFG_REG_W-1:0];
  endtask

  // Fill exposed unloaded entries; write both registers, maybe an unused one
  task automatic set_limits(input logic [CFG_DATA_W-1:0] vars_raw,
                            input logic [CFG_DATA_W-1:0] rows_raw);
    int nv;
    int nr;
    nv = clip(int'(vars_raw[CFG_REG_W-1:0]), N_VARS);
    nr = clip(int'(rows_raw[CFG_REG_W-1:0]), N_ROWS);
    for (int r = 0; r < nr; r++) begin
      if (!row_loaded[r]) load_row(ROW_IN_W'(r), pick_bound(), KIND_W'($urandom));
      for (int c = 0; c < nv; c++)
        if (!coef_loaded[r][c]) load_coef(ROW_IN_W'(r), COL_IN_W'(c), pick_coef());
    end
    settle();
    write_reg(CFG_NUM_VARS, vars_raw);
    write_reg(CFG_NUM_ROWS, rows_raw);
    if ($urandom_range(1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(15, int'(CFG_NUM_ROWS) + 1)), CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // One variable, no rows: 0, 1, then exhausted twice
    seek_next();
    seek_next();
    seek_next();
    seek_next();
    rewind_cursor();
    seek_next();
  endtask

  task automatic test_relations();
    // Equality that only vector 3 meets, using both coefficient extremes
    load_coef(0, 0, COEF_MAX);
    load_coef(0, 1, COEF_MIN);
    load_coef(0, 2, 16'sd1);
    load_row(0, -21'sd1, KIND_EQ);
    load_coef(1, 0, -16'sd1);
    load_coef(1, 1, 16'sd2);
    load_coef(1, 2, 16'sd3);
    load_row(1, BOUND_MAX, KIND_LE);
    load_coef(2, 0, 16'sd5);
    load_coef(2, 1, 16'sd5);
    load_coef(2, 2, 16'sd5);
    load_row(2, BOUND_MIN, KIND_GE);
    set_limits(8'h03, 8'h03);
    rewind_cursor();
    seek_next();
    seek_next();
    // Free row 0, then make row 1 unsatisfiable
    load_row(0, -21'sd1, KIND_NONE);
    rewind_cursor();
    seek_next();
    seek_next();
    load_row(1, BOUND_MIN, KIND_LE);
    seek_next();
  endtask

  task automatic test_space_edges();
    // No variables: only the empty vector
    set_limits(8'hE0, 8'hA0);
    rewind_cursor();
    seek_next();
    seek_next();
    // Saturate the variable count, no rows
    set_limits(8'h5F, 8'h40);
    seek_next();
    seek_next();
    seek_next();
    // Shrink the space below the cursor
    set_limits(8'h22, 8'h80);
    seek_next();
    rewind_cursor();
    seek_next();
  endtask

  // One random program: limits, full reload, rewind, then finds with noise
  task automatic run_episode();
    int nv;
    int nr;
    nv = $urandom_range(5, 1);
    nr = $urandom_range(4, 0);
    case ($urandom_range(9))
      0: nv = 0;
      1: begin
        nv = $urandom_range(8, 6);
        nr = $urandom_range(2, 0);
      end
      2: begin
        nv = $urandom_range(4, 1);
        nr = $urandom_range(31, 5);
      end
      default: ;
    endcase
    set_limits({3'($urandom), 5'(nv)}, {3'($urandom), 5'(nr)});
    for (int r = 0; r < clip(nr, N_ROWS); r++) begin
      load_row(ROW_IN_W'(r), pick_bound(), KIND_W'($urandom));
      for (int c = 0; c < nv; c++) load_coef(ROW_IN_W'(r), COL_IN_W'(c), pick_coef());
    end
    rewind_cursor();
    repeat ($urandom_range(12, 2)) begin
      case ($urandom_range(19))
        0: load_coef(ROW_IN_W'($urandom), COL_IN_W'($urandom), pick_coef());
        1: load_row(ROW_IN_W'($urandom), pick_bound(), KIND_W'($urandom));
        2: rewind_cursor();
        3: settle();
        default: seek_next();
      endcase
    end
  endtask

  task automatic test_random_search(input int send_pct, input int stall_pct, input int beats);
    int stop_at;
    send_gap_pct  = send_pct;
    rsp_stall_pct = stall_pct;
    stop_at       = beats_sent + beats;
    while (beats_sent < stop_at) run_episode();
  endtask

  // Compare each returned answer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: answer with none due: found=%0b solution=%h",
                 $time, rsp_ch.found, rsp_ch.solution);
        mismatches++;
      end else begin
        oldest = answers_due.pop_front();
        if (rsp_ch.found !== oldest.found) begin
          $display("%0t: found expected %0b, got %0b", $time, oldest.found, rsp_ch.found);
          mismatches++;
        end
        if (rsp_ch.solution !== oldest.solution) begin
          $display("%0t: solution expected %h, got %h",
                   $time, oldest.solution, rsp_ch.solution);
          mismatches++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Stop a run in which no channel moves a beat for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_binary_program_enumerator NOT OK");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_REWIND;
    req_ch.row   = '0;
    req_ch.col   = '0;
    req_ch.coef  = '0;
    req_ch.bound = '0;
    req_ch.kind  = KIND_EQ;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_NUM_VARS;
    cfg_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_relations();
    test_space_edges();
    test_random_search(30, 65, 190);
    test_random_search(65, 30, 180);
    test_random_search(0, 0, 180);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_binary_program_enumerator OK");
    else
      $display("tb_binary_program_enumerator NOT OK");
    $finish;
  end

endmodule
